>>> design/tkv_pkg.sv
`timescale 1ns / 1ps

package tkv_pkg;

   localparam int KEY_MAX_DEF = 32;
   localparam int CNT_W       = 6;
   localparam int RES_MAX     = 64;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef enum logic [1:0] {
      MODE_KEY,
      MODE_VALUE,
      MODE_DROP
   } line_mode_type;

   typedef enum logic [1:0] {
      ROLE_KEY_BYTE,
      ROLE_KEY_END,
      ROLE_VALUE_BYTE,
      ROLE_RECORD_END
   } role_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_KREAD,
      SEQ_KSEND,
      SEQ_EMIT
   } seq_state_type;

endpackage

>>> design/tkv_req_if.sv
`timescale 1ns / 1ps

interface tkv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

>>> design/tkv_rsp_if.sv
`timescale 1ns / 1ps

interface tkv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] role;
   logic       key_cut;
   logic       run_end;

   modport source (output valid, output out_byte, output role, output key_cut,
                   output run_end, input ready);
   modport sink (input valid, input out_byte, input role, input key_cut,
                 input run_end, output ready);
endinterface

>>> design/tkv_ram.sv
`timescale 1ns / 1ps

module tkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tab_key_value_line_splitter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// req_if    in         valid/ready        data_byte, buffer_end
// rsp_if    out        valid/ready        out_byte, role, key_cut, run_end
//
// A byte that causes no result is taken and leaves the sequencer idle; new bytes are taken only
// while no earlier byte still has results to send.
// Results are sent as the sink takes them; a TAB that closes a key of N stored bytes
// first reads the key memory (state SEQ_KREAD), then sends N key bytes and the key end.
// The output register lets the next byte be taken while the last result waits.
// Reset is synchronous and clears the line state; the key memory is not cleared.

module tab_key_value_line_splitter #(
   parameter int KEY_MAX = tkv_pkg::KEY_MAX_DEF
) (
   input logic          clock,
   input logic          reset,
   tkv_req_if.sink      req_if,
   tkv_rsp_if.source    rsp_if
);

   localparam int AddrW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam logic [tkv_pkg::CNT_W-1:0] KeyMaxC = tkv_pkg::CNT_W'(KEY_MAX);
   localparam logic [tkv_pkg::CNT_W-1:0] LimLast = tkv_pkg::CNT_W'(tkv_pkg::RES_MAX - 2);
   localparam logic [tkv_pkg::CNT_W-1:0] LimMid  = tkv_pkg::CNT_W'(tkv_pkg::RES_MAX - 1);

   tkv_pkg::seq_state_type seq_ff, seq_in;
   tkv_pkg::line_mode_type mode_ff, mode_in;
   logic [tkv_pkg::CNT_W-1:0] kc_ff, kc_in;
   logic                      ovf_ff, ovf_in;
   logic                      crh_ff, crh_in;
   logic [tkv_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [tkv_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                      pend_kend_ff, pend_kend_in;
   logic                      pend_cr_ff, pend_cr_in;
   logic                      pend_val_ff, pend_val_in;
   logic                      pend_rec_ff, pend_rec_in;
   logic                      cut_ff, cut_in;
   logic [7:0]                byte_ff, byte_in;

   logic                      rsp_valid_ff;
   logic [7:0]                rsp_byte_ff;
   tkv_pkg::role_type         rsp_role_ff;
   logic                      rsp_cut_ff;
   logic                      rsp_end_ff;

   logic                      load;
   logic [7:0]                load_byte;
   tkv_pkg::role_type         load_role;
   logic                      load_cut;
   logic                      load_end;
   logic                      slot_free;
   logic                      ram_we;
   logic [tkv_pkg::CNT_W-1:0] rd_idx;
   logic [7:0]                ram_rd;

   tkv_ram #(
      .WIDTH (8),
      .DEPTH (KEY_MAX)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (kc_ff[AddrW-1:0]),
      .wr_data (req_if.data_byte),
      .rd_addr (rd_idx[AddrW-1:0]),
      .rd_data (ram_rd)
   );

   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (seq_ff == tkv_pkg::SEQ_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.role     = rsp_role_ff;
   assign rsp_if.key_cut  = rsp_cut_ff;
   assign rsp_if.run_end  = rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= tkv_pkg::SEQ_IDLE;
         mode_ff      <= tkv_pkg::MODE_KEY;
         kc_ff        <= '0;
         ovf_ff       <= 1'b0;
         crh_ff       <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pend_kend_ff <= 1'b0;
         pend_cr_ff   <= 1'b0;
         pend_val_ff  <= 1'b0;
         pend_rec_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         kc_ff        <= kc_in;
         ovf_ff       <= ovf_in;
         crh_ff       <= crh_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pend_kend_ff <= pend_kend_in;
         pend_cr_ff   <= pend_cr_in;
         pend_val_ff  <= pend_val_in;
         pend_rec_ff  <= pend_rec_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cut_ff  <= cut_in;
      byte_ff <= byte_in;
      if (load) begin
         rsp_byte_ff <= load_byte;
         rsp_role_ff <= load_role;
         rsp_cut_ff  <= load_cut;
         rsp_end_ff  <= load_end;
      end
   end

   always_comb begin
      logic                      ended;
      logic                      flush;
      logic [tkv_pkg::CNT_W-1:0] lim;

      ended        = 1'b0;
      flush        = 1'b0;
      lim          = req_if.buffer_end ? LimLast : LimMid;
      seq_in       = seq_ff;
      mode_in      = mode_ff;
      kc_in        = kc_ff;
      ovf_in       = ovf_ff;
      crh_in       = crh_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_kend_in = pend_kend_ff;
      pend_cr_in   = pend_cr_ff;
      pend_val_in  = pend_val_ff;
      pend_rec_in  = pend_rec_ff;
      cut_in       = cut_ff;
      byte_in      = byte_ff;
      ram_we       = 1'b0;
      rd_idx       = idx_ff;
      load         = 1'b0;
      load_byte    = 8'h00;
      load_role    = tkv_pkg::ROLE_RECORD_END;
      load_cut     = 1'b0;
      load_end     = 1'b0;

      unique case (seq_ff)
         tkv_pkg::SEQ_IDLE: begin
            if (req_if.valid) begin
               byte_in      = req_if.data_byte;
               pend_kend_in = 1'b0;
               pend_cr_in   = 1'b0;
               pend_val_in  = 1'b0;
               pend_rec_in  = 1'b0;
               unique case (mode_ff)
                  tkv_pkg::MODE_KEY: begin
                     if (req_if.data_byte == tkv_pkg::CH_LF) begin
                        ended = 1'b1;
                     end else if (req_if.data_byte == tkv_pkg::CH_TAB) begin
                        if (kc_ff == '0) begin
                           mode_in = tkv_pkg::MODE_DROP;
                        end else begin
                           flush        = 1'b1;
                           cnt_in       = (kc_ff > lim) ? lim : kc_ff;
                           cut_in       = ovf_ff || (kc_ff > lim);
                           idx_in       = '0;
                           pend_kend_in = 1'b1;
                           mode_in      = tkv_pkg::MODE_VALUE;
                           crh_in       = 1'b0;
                        end
                     end else if (kc_ff < KeyMaxC) begin
                        ram_we = 1'b1;
                        kc_in  = kc_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  tkv_pkg::MODE_VALUE: begin
                     if (req_if.data_byte == tkv_pkg::CH_LF) begin
                        pend_rec_in = 1'b1;
                        ended       = 1'b1;
                     end else begin
                        pend_cr_in  = crh_ff;
                        crh_in      = (req_if.data_byte == tkv_pkg::CH_CR);
                        pend_val_in = (req_if.data_byte != tkv_pkg::CH_CR);
                     end
                  end
                  default: begin
                     if (req_if.data_byte == tkv_pkg::CH_LF) begin
                        ended = 1'b1;
                     end
                  end
               endcase
               if (req_if.buffer_end && !ended && mode_in == tkv_pkg::MODE_VALUE) begin
                  pend_rec_in = 1'b1;
               end
               if (ended || req_if.buffer_end) begin
                  kc_in   = '0;
                  ovf_in  = 1'b0;
                  crh_in  = 1'b0;
                  mode_in = tkv_pkg::MODE_KEY;
               end
               if (flush) begin
                  seq_in = tkv_pkg::SEQ_KREAD;
               end else if (pend_cr_in || pend_val_in || pend_rec_in) begin
                  seq_in = tkv_pkg::SEQ_EMIT;
               end
            end
         end
         tkv_pkg::SEQ_KREAD: begin
            seq_in = tkv_pkg::SEQ_KSEND;
         end
         tkv_pkg::SEQ_KSEND: begin
            if (slot_free) begin
               load      = 1'b1;
               load_byte = ram_rd;
               load_role = tkv_pkg::ROLE_KEY_BYTE;
               idx_in    = idx_ff + 1'b1;
               if (idx_in == cnt_ff) begin
                  seq_in = tkv_pkg::SEQ_EMIT;
               end else begin
                  rd_idx = idx_in;
               end
            end
         end
         tkv_pkg::SEQ_EMIT: begin
            if (slot_free) begin
               load = 1'b1;
               if (pend_kend_ff) begin
                  load_role    = tkv_pkg::ROLE_KEY_END;
                  load_cut     = cut_ff;
                  load_end     = !(pend_cr_ff || pend_val_ff || pend_rec_ff);
                  pend_kend_in = 1'b0;
               end else if (pend_cr_ff) begin
                  load_byte  = tkv_pkg::CH_CR;
                  load_role  = tkv_pkg::ROLE_VALUE_BYTE;
                  load_end   = !(pend_val_ff || pend_rec_ff);
                  pend_cr_in = 1'b0;
               end else if (pend_val_ff) begin
                  load_byte   = byte_ff;
                  load_role   = tkv_pkg::ROLE_VALUE_BYTE;
                  load_end    = !pend_rec_ff;
                  pend_val_in = 1'b0;
               end else begin
                  load_end    = 1'b1;
                  pend_rec_in = 1'b0;
               end
               if (load_end) begin
                  seq_in = tkv_pkg::SEQ_IDLE;
               end
            end
         end
         default: begin
            seq_in = tkv_pkg::SEQ_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      kc_ff <= KeyMaxC)
      else $error("stored key length beyond key memory depth");

   a_flush_index: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == tkv_pkg::SEQ_KSEND) |-> (idx_ff < cnt_ff))
      else $error("key flush index ran past the key length");

   a_key_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (load && load_role == tkv_pkg::ROLE_KEY_BYTE) |-> !load_end)
      else $error("key byte marked as last word of a run");

   a_run_end_idle: assert property (@(posedge clock) disable iff (reset)
      (load && load_end) |=> (seq_ff == tkv_pkg::SEQ_IDLE))
      else $error("sequencer busy after last word of a run");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == tkv_pkg::SEQ_IDLE) |->
         !(pend_kend_ff || pend_cr_ff || pend_val_ff || pend_rec_ff))
      else $error("pending words left while idle");
`endif

endmodule

>>> verif/tb_tab_key_value_line_splitter.sv
`timescale 1ns / 1ps

module tb_tab_key_value_line_splitter;

   localparam int KEY_SLOTS = tkv_pkg::KEY_MAX_DEF;

   typedef struct {
      logic [7:0] data_byte;
      logic       buffer_end;
   } byte_item_type;

   typedef struct {
      logic [7:0]        out_byte;
      tkv_pkg::role_type role;
      logic              key_cut;
      logic              run_end;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tkv_req_if req_ch ();
   tkv_rsp_if rsp_ch ();

   tab_key_value_line_splitter #(.KEY_MAX(KEY_SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #10 clock = ~clock;

   byte_item_type pending[$];
   byte_item_type head_item;
   rsp_word_type  due_words[$];
   rsp_word_type  step_words[$];
   rsp_word_type  want;

   logic [7:0]             key_mem [0:KEY_SLOTS-1];
   int                     key_len = 0;
   logic                   key_trunc = 1'b0;
   logic                   cr_pend = 1'b0;
   tkv_pkg::line_mode_type line_state = tkv_pkg::MODE_KEY;

   int send_gap = 21;
   int recv_gap = 62;
   int hold_left = 0;
   int queued = 0;
   int bytes_in = 0;
   int words_out = 0;
   int records_seen = 0;
   int cuts_seen = 0;
   int errors = 0;

   function void restart_line();
      key_len = 0;
      key_trunc = 1'b0;
      cr_pend = 1'b0;
      line_state = tkv_pkg::MODE_KEY;
   endfunction

   function void add_word(input logic [7:0] b, input tkv_pkg::role_type r, input logic cut);
      rsp_word_type w;
      if (step_words.size() >= tkv_pkg::RES_MAX)
         return;
      w.out_byte = b;
      w.role = r;
      w.key_cut = cut;
      w.run_end = 1'b0;
      step_words.push_back(w);
   endfunction

   // Works out the words that one accepted byte causes and queues them.
   function automatic void split_byte(input logic [7:0] b, input logic last);
      int cnt;
      int lim;
      int i;
      logic cut;
      logic ended;
      rsp_word_type w;
      step_words.delete();
      ended = 1'b0;
      case (line_state)
         tkv_pkg::MODE_KEY: begin
            if (b == tkv_pkg::CH_LF) begin
               restart_line();
               ended = 1'b1;
            end else if (b == tkv_pkg::CH_TAB) begin
               if (key_len == 0) begin
                  line_state = tkv_pkg::MODE_DROP;
               end else begin
                  cnt = key_len;
                  cut = key_trunc;
                  lim = last ? tkv_pkg::RES_MAX - 2 : tkv_pkg::RES_MAX - 1;
                  if (cnt > lim) begin
                     cnt = lim;
                     cut = 1'b1;
                  end
                  for (i = 0; i < cnt && i < KEY_SLOTS; i++)
                     add_word(key_mem[i], tkv_pkg::ROLE_KEY_BYTE, 1'b0);
                  add_word(8'h00, tkv_pkg::ROLE_KEY_END, cut);
                  line_state = tkv_pkg::MODE_VALUE;
                  cr_pend = 1'b0;
               end
            end else if (key_len < KEY_SLOTS) begin
               key_mem[key_len] = b;
               key_len++;
            end else begin
               key_trunc = 1'b1;
            end
         end
         tkv_pkg::MODE_VALUE: begin
            if (b == tkv_pkg::CH_LF) begin
               add_word(8'h00, tkv_pkg::ROLE_RECORD_END, 1'b0);
               restart_line();
               ended = 1'b1;
            end else begin
               if (cr_pend)
                  add_word(tkv_pkg::CH_CR, tkv_pkg::ROLE_VALUE_BYTE, 1'b0);
               cr_pend = (b == tkv_pkg::CH_CR);
               if (b != tkv_pkg::CH_CR)
                  add_word(b, tkv_pkg::ROLE_VALUE_BYTE, 1'b0);
            end
         end
         default: begin
            if (b == tkv_pkg::CH_LF) begin
               restart_line();
               ended = 1'b1;
            end
         end
      endcase
      if (last && !ended) begin
         if (line_state == tkv_pkg::MODE_VALUE)
            add_word(8'h00, tkv_pkg::ROLE_RECORD_END, 1'b0);
         restart_line();
      end
      for (i = 0; i < step_words.size(); i++) begin
         w = step_words[i];
         w.run_end = (i == step_words.size() - 1);
         due_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            split_byte(req_ch.data_byte, req_ch.buffer_end);
            bytes_in++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_gap) begin
               head_item = pending.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.data_byte <= head_item.data_byte;
               req_ch.buffer_end <= head_item.buffer_end;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_out++;
         if (rsp_ch.role == tkv_pkg::ROLE_RECORD_END)
            records_seen++;
         if (rsp_ch.role == tkv_pkg::ROLE_KEY_END && rsp_ch.key_cut)
            cuts_seen++;
         if (due_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: byte %02h role %0d cut %0b end %0b",
                        rsp_ch.out_byte, rsp_ch.role, rsp_ch.key_cut, rsp_ch.run_end);
         end else begin
            want = due_words.pop_front();
            if (rsp_ch.out_byte !== want.out_byte || rsp_ch.role !== want.role ||
                rsp_ch.key_cut !== want.key_cut || rsp_ch.run_end !== want.run_end) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected byte %02h role %0d cut %0b end %0b, ",
                            "got byte %02h role %0d cut %0b end %0b"},
                           want.out_byte, want.role, want.key_cut, want.run_end,
                           rsp_ch.out_byte, rsp_ch.role, rsp_ch.key_cut, rsp_ch.run_end);
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic last);
      byte_item_type it;
      it.data_byte = b;
      it.buffer_end = last;
      pending.push_back(it);
      queued++;
   endtask

   // In these strings '|' stands for TAB, '~' for LF and '^' for CR.
   task automatic queue_text(input string s, input logic last_on_final);
      int i;
      logic [7:0] b;
      for (i = 0; i < s.len(); i++) begin
         b = s[i];
         if (b == "|")
            b = tkv_pkg::CH_TAB;
         else if (b == "~")
            b = tkv_pkg::CH_LF;
         else if (b == "^")
            b = tkv_pkg::CH_CR;
         queue_byte(b, last_on_final && i == s.len() - 1);
      end
   endtask

   task automatic queue_random_record();
      int kind;
      int klen;
      int vlen;
      int term;
      int i;
      logic [7:0] b;
      logic [7:0] rec[$];
      kind = $urandom_range(9);
      if (kind == 0) begin
         vlen = $urandom_range(1, 6);
         for (i = 0; i < vlen; i++)
            queue_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
         if (kind == 1)
            klen = 0;
         else if ($urandom_range(11) == 0)
            klen = $urandom_range(30, 36);
         else
            klen = $urandom_range(1, 6);
         for (i = 0; i < klen; i++) begin
            b = 8'($urandom_range(255));
            if (b == tkv_pkg::CH_LF || b == tkv_pkg::CH_TAB)
               b = tkv_pkg::CH_CR;
            rec.push_back(b);
         end
         if (kind != 2)
            rec.push_back(tkv_pkg::CH_TAB);
         vlen = $urandom_range(0, 6);
         for (i = 0; i < vlen; i++) begin
            b = ($urandom_range(4) == 0) ? tkv_pkg::CH_CR : 8'($urandom_range(255));
            if (b == tkv_pkg::CH_LF)
               b = tkv_pkg::CH_TAB;
            rec.push_back(b);
         end
         term = $urandom_range(3);
         if (term == 2)
            rec.push_back(tkv_pkg::CH_CR);
         if (term != 3)
            rec.push_back(tkv_pkg::CH_LF);
         for (i = 0; i < rec.size(); i++)
            queue_byte(rec[i], term == 3 && i == rec.size() - 1);
      end
   endtask

   task automatic wait_sent();
      while (pending.size() != 0 || req_ch.valid)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_ch.valid || due_words.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int i;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.buffer_end = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_text("m|n^~", 1'b1);
      queue_text("|x|y~", 1'b0);
      queue_text("k^|v^z~", 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(tkv_pkg::CH_TAB, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_text("K|", 1'b1);
      queue_text("x|y^", 1'b1);
      queue_text("z", 1'b1);
      wait_drained();
      repeat (5) @(posedge clock);

      // A key longer than the store while the receiver holds off.
      hold_left <= 200;
      for (i = 0; i < 34; i++)
         queue_byte(8'(8'h41 + i % 26), 1'b0);
      queue_text("|value!~", 1'b0);
      @(posedge clock);
      while (hold_left != 0)
         @(posedge clock);
      wait_sent();

      queued = 0;
      while (queued < 15)
         queue_random_record();
      wait_sent();
      send_gap <= 62;
      recv_gap <= 21;
      queued = 0;
      while (queued < 15)
         queue_random_record();
      wait_sent();
      send_gap <= 0;
      recv_gap <= 0;
      queued = 0;
      while (queued < 15)
         queue_random_record();

      wait_drained();
      repeat (20) @(posedge clock);
      if (due_words.size() != 0) begin
         errors += due_words.size();
         $display("%0d expected words never arrived", due_words.size());
      end
      $display("Sent %0d bytes and checked %0d words,", bytes_in, words_out);
      $display("closing %0d records with %0d cut keys; mismatches counted: %0d.",
               records_seen, cuts_seen, errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
